// ----- sv/rational_arithmetic_unit_assert.svh -----
// Assertion macros shared by the checker of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RAU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rau_pkg.sv -----
// Types, constants and the control program of the rational arithmetic unit.
package rau_pkg;

	localparam int RAU_OPERAND_WIDTH = 16;
	localparam int ACTION_W          = 2;
	localparam int PC_W              = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	// Operand pair fed to the shared multiplier.
	typedef enum logic [1:0] {
		MS_NUM_A,
		MS_NUM_B,
		MS_DEN
	} mul_sel_t;

	typedef enum logic [1:0] {
		NUM_HOLD,
		NUM_LOAD,
		NUM_ACC
	} num_op_t;

	typedef enum logic [2:0] {
		DV_IDLE,
		DV_INIT_GCD,
		DV_INIT_NUM,
		DV_INIT_DEN,
		DV_STEP
	} div_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_ZERO_PAIR,
		C_M_ZERO,
		C_DIV_BUSY,
		C_OUT_BLOCKED
	} cond_t;

	typedef logic [PC_W-1:0] pc_t;

	// Program addresses.
	localparam pc_t S_IDLE  = 4'd0;
	localparam pc_t S_MUL1  = 4'd1;
	localparam pc_t S_MUL2  = 4'd2;
	localparam pc_t S_MUL3  = 4'd3;
	localparam pc_t S_DEN   = 4'd4;
	localparam pc_t S_PREP  = 4'd5;
	localparam pc_t S_LOOP  = 4'd6;
	localparam pc_t S_DIVG  = 4'd7;
	localparam pc_t S_SWAP  = 4'd8;
	localparam pc_t S_SIGN  = 4'd9;
	localparam pc_t S_DIVN  = 4'd10;
	localparam pc_t S_NEXTD = 4'd11;
	localparam pc_t S_DIVD  = 4'd12;
	localparam pc_t S_OUT   = 4'd13;
	localparam pc_t S_BACK  = 4'd14;

	typedef struct packed {
		mul_sel_t mul_sel;
		num_op_t  num_op;
		logic     den_load;
		logic     gcd_init;
		div_op_t  div_op;
		logic     gcd_swap;
		logic     sign_load;
		logic     qn_load;
		logic     out_write;
		cond_t    cond;
		pc_t      target;
	} ctrl_t;

	// Control store: one word per step. A step jumps to target when its
	// condition holds and falls through to the next address otherwise.
	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t cw;
		cw           = '0;
		cw.mul_sel   = MS_NUM_A;
		cw.num_op    = NUM_HOLD;
		cw.div_op    = DV_IDLE;
		cw.cond      = C_NEVER;
		cw.target    = S_IDLE;
		unique case (pc)
			S_IDLE: begin
				cw.cond   = C_NO_START;
				cw.target = S_IDLE;
			end
			S_MUL1: begin
				cw.mul_sel = MS_NUM_A;
			end
			S_MUL2: begin
				cw.mul_sel = MS_NUM_B;
				cw.num_op  = NUM_LOAD;
			end
			S_MUL3: begin
				cw.mul_sel = MS_DEN;
				cw.num_op  = NUM_ACC;
			end
			S_DEN: begin
				cw.den_load = 1'b1;
			end
			S_PREP: begin
				cw.gcd_init = 1'b1;
				cw.cond     = C_ZERO_PAIR;
				cw.target   = S_OUT;
			end
			S_LOOP: begin
				cw.div_op = DV_INIT_GCD;
				cw.cond   = C_M_ZERO;
				cw.target = S_SIGN;
			end
			S_DIVG: begin
				cw.div_op = DV_STEP;
				cw.cond   = C_DIV_BUSY;
				cw.target = S_DIVG;
			end
			S_SWAP: begin
				cw.gcd_swap = 1'b1;
				cw.cond     = C_ALWAYS;
				cw.target   = S_LOOP;
			end
			S_SIGN: begin
				cw.sign_load = 1'b1;
				cw.div_op    = DV_INIT_NUM;
			end
			S_DIVN: begin
				cw.div_op = DV_STEP;
				cw.cond   = C_DIV_BUSY;
				cw.target = S_DIVN;
			end
			S_NEXTD: begin
				cw.qn_load = 1'b1;
				cw.div_op  = DV_INIT_DEN;
			end
			S_DIVD: begin
				cw.div_op = DV_STEP;
				cw.cond   = C_DIV_BUSY;
				cw.target = S_DIVD;
			end
			S_OUT: begin
				cw.out_write = 1'b1;
				cw.cond      = C_OUT_BLOCKED;
				cw.target    = S_OUT;
			end
			S_BACK: begin
				cw.cond   = C_ALWAYS;
				cw.target = S_IDLE;
			end
			default: begin
				cw.cond   = C_ALWAYS;
				cw.target = S_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

// ----- sv/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: fraction add/sub/mul/div with Euclid gcd reduction.
//
//  channel   | direction | tdata fields (low bit up)           | tuser
//  ----------+-----------+-------------------------------------+---------
//  s_*       | in        | a_num, a_den, b_num, b_den          | action
//  m_*       | out       | res_num, res_den, zero padding      | zero_gcd
//
// An item runs the multiply steps, the Euclid remainder steps on the
// bit-serial divider, one quotient bit per cycle, and the exact divisions of
// numerator and denominator by the gcd before it reaches the result
// register; an item whose numerator and denominator are both zero goes
// straight from the gcd setup to the result. Reset clears the sequencer, the
// divider bit counter and the result valid flag only. A result waiting on
// m_tready stalls the sequencer only at its final step; the next item is
// accepted while the previous result waits.
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = RAU_OPERAND_WIDTH
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// s_tdata: a_num, a_den, b_num, b_den
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]         s_tdata,
	// s_tuser: action
	input  logic [ACTION_W-1:0]                          s_tuser,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// m_tdata: res_num, res_den, zero padding
	output logic [((4*OPERAND_WIDTH+1+7)/8)*8-1:0]       m_tdata,
	// m_tuser: zero_gcd
	output logic                                         m_tuser
);

	localparam int W     = OPERAND_WIDTH;
	localparam int NW    = 2*W + 1;      // numerator width
	localparam int DW    = 2*W;          // denominator width
	localparam int MW    = 2*W;          // magnitude width used by the gcd
	localparam int OUT_W = ((4*W+1+7)/8)*8;
	localparam int PAD_W = OUT_W - NW - DW;
	localparam int CNT_W = $clog2(MW);

	// Sequencer.
	pc_t   pc_q, pc_d;
	ctrl_t cw;
	logic  cond_hit;
	logic  accept;

	// Operands.
	action_t               act_q;
	logic signed [W-1:0]   an_q, ad_q, bn_q, bd_q;

	// Multiplier and unreduced pair.
	logic signed [W-1:0]   opx, opy;
	logic signed [DW-1:0]  prod, p_q;
	logic signed [NW-1:0]  p_ext;
	logic signed [NW-1:0]  num_q;
	logic signed [DW-1:0]  den_q;
	logic signed [NW-1:0]  num_abs;
	logic        [MW-1:0]  num_mag, den_mag;
	logic                  zero_pair;

	// Euclid state and the shared divider.
	logic [MW-1:0]   n_q, m_q;
	logic            par_q;
	logic            gneg_q;
	logic [MW-1:0]   rem_q, quo_q, dsr_q, qn_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MW:0]     shifted, diff;
	logic            ge;
	logic            div_busy;

	// Result.
	logic                 out_free;
	logic                 m_tvalid_q;
	logic signed [NW-1:0] res_num;
	logic signed [DW-1:0] res_den;
	logic signed [NW-1:0] qn_ext;

	assign s_tready = (pc_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	// Control word and next step.
	always_comb begin
		cw = ucode(pc_q);
		unique case (cw.cond)
			C_NEVER:       cond_hit = 1'b0;
			C_ALWAYS:      cond_hit = 1'b1;
			C_NO_START:    cond_hit = !accept;
			C_ZERO_PAIR:   cond_hit = zero_pair;
			C_M_ZERO:      cond_hit = (m_q == '0);
			C_DIV_BUSY:    cond_hit = div_busy;
			C_OUT_BLOCKED: cond_hit = !out_free;
			default:       cond_hit = 1'b0;
		endcase
		pc_d = cond_hit ? cw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Operand capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(s_tuser);
			an_q  <= s_tdata[W-1:0];
			ad_q  <= s_tdata[2*W-1:W];
			bn_q  <= s_tdata[3*W-1:2*W];
			bd_q  <= s_tdata[4*W-1:3*W];
		end
	end

	// One shared multiplier; the product is registered before use.
	always_comb begin
		unique case (cw.mul_sel)
			MS_NUM_A: begin
				opx = an_q;
				opy = (act_q == ACT_MUL) ? bn_q : bd_q;
			end
			MS_NUM_B: begin
				opx = bn_q;
				opy = ad_q;
			end
			MS_DEN: begin
				opx = ad_q;
				opy = (act_q == ACT_DIV) ? bn_q : bd_q;
			end
			default: begin
				opx = an_q;
				opy = bd_q;
			end
		endcase
		prod  = opx * opy;
		p_ext = {p_q[DW-1], p_q};
	end

	always_ff @(posedge clk) begin
		p_q <= prod;
		unique case (cw.num_op)
			NUM_HOLD: num_q <= num_q;
			NUM_LOAD: num_q <= p_ext;
			NUM_ACC: begin
				unique case (act_q)
					ACT_ADD: num_q <= num_q + p_ext;
					ACT_SUB: num_q <= num_q - p_ext;
					ACT_MUL: num_q <= num_q;
					ACT_DIV: num_q <= num_q;
				endcase
			end
			default: num_q <= num_q;
		endcase
		if (cw.den_load) begin
			den_q <= p_q;
		end
	end

	// Magnitudes of the unreduced pair; both fit in MW bits.
	always_comb begin
		num_abs   = num_q[NW-1] ? -num_q : num_q;
		num_mag   = num_abs[MW-1:0];
		den_mag   = den_q[DW-1] ? MW'(-den_q) : MW'(den_q);
		zero_pair = (num_q == '0) && (den_q == '0);
	end

	// Restoring divider step: one quotient bit per cycle, dividend shifts
	// out of quo_q while quotient bits shift in.
	always_comb begin
		shifted  = {rem_q, quo_q[MW-1]};
		ge       = shifted >= {1'b0, dsr_q};
		diff     = shifted - {1'b0, dsr_q};
		div_busy = (cnt_q != CNT_W'(MW-1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (cw.div_op)
				DV_INIT_GCD, DV_INIT_NUM, DV_INIT_DEN: cnt_q <= '0;
				DV_STEP: cnt_q <= cnt_q + 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.div_op)
			DV_INIT_GCD: begin
				rem_q <= '0;
				quo_q <= n_q;
				dsr_q <= m_q;
			end
			DV_INIT_NUM: begin
				rem_q <= '0;
				quo_q <= num_mag;
				dsr_q <= n_q;
			end
			DV_INIT_DEN: begin
				// The divisor still holds the gcd magnitude.
				rem_q <= '0;
				quo_q <= den_mag;
			end
			DV_STEP: begin
				rem_q <= ge ? diff[MW-1:0] : shifted[MW-1:0];
				quo_q <= {quo_q[MW-2:0], ge};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase

		// Euclid runs on magnitudes. A truncating remainder takes the sign
		// of its dividend, so the signs in the sequence alternate between
		// that of the denominator and that of the numerator; par_q tracks
		// which one the current n_q carries.
		if (cw.gcd_init) begin
			n_q   <= den_mag;
			m_q   <= num_mag;
			par_q <= 1'b0;
		end else if (cw.gcd_swap) begin
			n_q   <= m_q;
			m_q   <= rem_q;
			par_q <= ~par_q;
		end
		if (cw.sign_load) begin
			gneg_q <= par_q ? num_q[NW-1] : den_q[DW-1];
		end
		if (cw.qn_load) begin
			qn_q <= quo_q;
		end
	end

	// The divisions by the gcd are exact, so each quotient is the magnitude
	// quotient with the sign of the part xor the sign of the gcd.
	always_comb begin
		qn_ext = {{(NW-MW){1'b0}}, qn_q};
		if (zero_pair) begin
			res_num = num_q;
			res_den = den_q;
		end else begin
			res_num = (num_q[NW-1] ^ gneg_q) ? -qn_ext : qn_ext;
			res_den = (den_q[DW-1] ^ gneg_q) ? -quo_q : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cw.out_write && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_write && out_free) begin
			m_tdata <= {{PAD_W{1'b0}}, res_den, res_num};
			m_tuser <= zero_pair;
		end
	end

endmodule

// ----- sv/rau_checker.sv -----
// Port-level checker for the rational arithmetic unit and its bind.
`include "rational_arithmetic_unit_assert.svh"

module rau_checker
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = RAU_OPERAND_WIDTH
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_tdata,
	input logic [ACTION_W-1:0]                    s_tuser,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [((4*OPERAND_WIDTH+1+7)/8)*8-1:0] m_tdata,
	input logic                                   m_tuser
);

	localparam int NW = 2*OPERAND_WIDTH + 1;
	localparam int DW = 2*OPERAND_WIDTH;
	localparam logic [DW-1:0] DEN_ONE = DW'(1);

	logic s_acc;
	logic m_num_zero;
	logic m_den_one;

	assign s_acc      = s_tvalid && s_tready;
	assign m_num_zero = (m_tdata[NW-1:0] == '0);
	assign m_den_one  = (m_tdata[NW+DW-1:NW] == DEN_ONE);

	// A waiting result holds still.
	`RAU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	// The block works on one item at a time.
	`RAU_ASSERT_NEXT(a_one_item, s_acc, !s_tready, "second item accepted while busy")
	// The zero flag comes only with an all-zero pair.
	`RAU_ASSERT_SAME(a_zero_flag, m_tvalid && m_tuser, m_tdata == '0, "zero flag with nonzero data")
	// A reduced zero numerator leaves a denominator of one.
	`RAU_ASSERT_SAME(a_zero_num, m_tvalid && !m_tuser && m_num_zero, m_den_one, "zero not reduced to 0/1")

endmodule

bind rational_arithmetic_unit rau_checker #(
	.OPERAND_WIDTH(OPERAND_WIDTH)
) u_rau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- bench/rational_arithmetic_unit_test.sv -----
// Self-checking testbench of the rational arithmetic unit: directed and random fractions.
module rational_arithmetic_unit_test;
	import rau_pkg::*;

	localparam int W = RAU_OPERAND_WIDTH;
	localparam int S_DATA_W = ((4*W+7)/8)*8;
	localparam int M_DATA_W = ((4*W+1+7)/8)*8;
	localparam int RANDOM_ITEMS = 1200;
	// Worst case from acceptance to result, with margin.
	localparam int DRAIN_CYCLES = 11 + 4*W + 48*(2*W+2);

	typedef struct packed {
		logic [2*W:0]   num;
		logic [2*W-1:0] den;
		logic           zero;
	} fraction_t;

	typedef struct {
		action_t act;
		int      an, ad, bn, bd;
		bit      typed;
		longint  want_num, want_den;
		bit      want_zero;
	} vector_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [ACTION_W-1:0] s_tuser = ACT_ADD;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	fraction_t pending_fractions[$];
	int        n_fail = 0;
	bit        calm = 1'b0;
	int        stall_left = 0;

	rational_arithmetic_unit #(.OPERAND_WIDTH(W)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Cross products at full width, then Euclid on (den, num) with C-style
	// truncating remainder, so the gcd may come out negative.
	function automatic fraction_t reduce_fraction(input action_t act,
			input logic signed [W-1:0] an, ad, bn, bd);
		longint num, den, n, m, r;
		fraction_t res;
		case (act)
			ACT_ADD: begin
				num = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
				den = longint'(ad) * longint'(bd);
			end
			ACT_SUB: begin
				num = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
				den = longint'(ad) * longint'(bd);
			end
			ACT_MUL: begin
				num = longint'(an) * longint'(bn);
				den = longint'(ad) * longint'(bd);
			end
			default: begin
				num = longint'(an) * longint'(bd);
				den = longint'(ad) * longint'(bn);
			end
		endcase
		n = den;
		m = num;
		while (m != 0) begin
			r = n % m;
			n = m;
			m = r;
		end
		res.zero = (n == 0);
		if (n != 0) begin
			num = num / n;
			den = den / n;
		end
		res.num = num[2*W:0];
		res.den = den[2*W-1:0];
		return res;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// Operand mix: range extremes, small values (zeros included) and full-range words.
	function automatic int pick_operand();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				case ($urandom_range(0, 4))
					0: return -(1 << (W-1));
					1: return (1 << (W-1)) - 1;
					2: return 0;
					3: return 1;
					default: return -1;
				endcase
			end
			1, 2, 3, 4: return $urandom_range(0, 40) - 20;
			default: return int'($signed(W'($urandom)));
		endcase
	endfunction

	task automatic send_item(input action_t act, input int an, ad, bn, bd,
			input bit typed, input fraction_t want);
		int gap;
		gap = calm ? 0 : idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {W'(bd), W'(bn), W'(ad), W'(an)};
		do @(posedge clk); while (!s_tready);
		if (typed)
			pending_fractions.push_back(want);
		else
			pending_fractions.push_back(reduce_fraction(act, W'(an), W'(ad), W'(bn), W'(bd)));
	endtask

	task automatic wait_drained();
		while (pending_fractions.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, none during calm stretches.
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= idle_gap();
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		fraction_t want;
		logic [2*W:0] got_num;
		logic [2*W-1:0] got_den;
		if (arst_n && m_tvalid && m_tready) begin
			got_num = m_tdata[2*W:0];
			got_den = m_tdata[4*W:2*W+1];
			if (pending_fractions.size() == 0) begin
				$error("unexpected result: res_num %0d res_den %0d", $signed(got_num),
					$signed(got_den));
				n_fail++;
			end else begin
				want = pending_fractions.pop_front();
				if (got_num !== want.num) begin
					$error("res_num: expected %0d, got %0d", $signed(want.num),
						$signed(got_num));
					n_fail++;
				end
				if (got_den !== want.den) begin
					$error("res_den: expected %0d, got %0d", $signed(want.den),
						$signed(got_den));
					n_fail++;
				end
				if (m_tuser !== want.zero) begin
					$error("zero_gcd: expected %0d, got %0d", want.zero, m_tuser);
					n_fail++;
				end
			end
		end
	end

	initial begin
		vector_t   directed[];
		fraction_t want;
		int        lo, hi;
		lo = -(1 << (W-1));
		hi = (1 << (W-1)) - 1;
		directed = '{
			// Both parts zero: pair passed through, flag set.
			'{ACT_ADD, 0, 0, 0, 0, 1, 0, 0, 1},
			'{ACT_MUL, 0, 0, 5, 7, 1, 0, 0, 1},
			'{ACT_DIV, 0, 0, 0, 0, 1, 0, 0, 1},
			// Zero denominator with nonzero numerator reduces to 1/0.
			'{ACT_MUL, 1, 0, 1, 1, 1, 1, 0, 0},
			'{ACT_DIV, 2, 3, 0, 5, 1, 1, 0, 0},
			'{ACT_MUL, -7, 0, 3, 0, 1, 1, 0, 0},
			// Negative gcd flips the signs: -2/4 becomes 1/-2.
			'{ACT_MUL, -1, 1, 2, 4, 1, 1, -2, 0},
			'{ACT_MUL, lo, 1, lo, 1, 1, 64'sd1 << (2*W-2), 1, 0},
			'{ACT_ADD, lo, lo, lo, lo, 1, 2, 1, 0},
			'{ACT_SUB, 3, 4, 3, 4, 1, 0, 1, 0},
			'{ACT_ADD, 1, 2, 1, 3, 0, 0, 0, 0},
			'{ACT_ADD, 1, -1, 1, -1, 0, 0, 0, 0},
			'{ACT_ADD, hi, hi, hi, hi, 0, 0, 0, 0},
			'{ACT_SUB, hi, lo, lo, hi, 0, 0, 0, 0},
			'{ACT_SUB, lo, 1, hi, 1, 0, 0, 0, 0},
			'{ACT_MUL, hi, hi, hi, lo, 0, 0, 0, 0},
			'{ACT_DIV, lo, hi, hi, lo, 0, 0, 0, 0},
			'{ACT_DIV, hi, 1, lo, 1, 0, 0, 0, 0},
			'{ACT_DIV, -1, -1, -1, -1, 0, 0, 0, 0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			want.num  = directed[k].want_num[2*W:0];
			want.den  = directed[k].want_den[2*W-1:0];
			want.zero = directed[k].want_zero;
			send_item(directed[k].act, directed[k].an, directed[k].ad, directed[k].bn,
				directed[k].bd, directed[k].typed, want);
		end

		// Hold the sender off until the unit has emptied once.
		s_tvalid <= 1'b0;
		wait_drained();

		want = '0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = ((i / 150) % 4) == 1;
			if (i == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				wait_drained();
			end
			send_item(action_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
				pick_operand(), pick_operand(), 1'b0, want);
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Far beyond the slowest legal run: every item at its longest Euclid chain
	// plus the longest stalls on both sides.
	initial begin
		#400_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/rau_pkg.sv
sv/rational_arithmetic_unit.sv
sv/rau_checker.sv
bench/rational_arithmetic_unit_test.sv
